>>> design/sip_pkg.sv
// Shared types, constants and the SipRound function for the SipHash-2-4 unit.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package sip_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'd1;

    localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] SIP_FINAL_XOR = 64'h00000000000000ff;
    localparam int unsigned LEN_SHIFT = 56;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } t_sip_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // take an input word (init on message start) and run a round
        logic inject;  // absorb the length-only block and run a round
        logic fin;     // flip v2 for finalization and run a round
        logic step;    // plain round
        logic mix;     // fold the current block into v0 after the round
        logic done;    // load the hash into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;      // input word is absorbed as a full word
        logic out_free;  // output register can take a new hash this cycle
    } t_status;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic t_sip_state sip_permute(input t_sip_state s);
        t_sip_state r;
        r = s;
        r.v0 = r.v0 + r.v1;
        r.v2 = r.v2 + r.v3;
        r.v1 = rotl(r.v1, 13);
        r.v3 = rotl(r.v3, 16);
        r.v1 = r.v1 ^ r.v0;
        r.v3 = r.v3 ^ r.v2;
        r.v0 = rotl(r.v0, 32);
        r.v2 = r.v2 + r.v1;
        r.v0 = r.v0 + r.v3;
        r.v1 = rotl(r.v1, 17);
        r.v3 = rotl(r.v3, 21);
        r.v1 = r.v1 ^ r.v2;
        r.v3 = r.v3 ^ r.v0;
        r.v2 = rotl(r.v2, 32);
        sip_permute = r;
    endfunction

endpackage

`default_nettype wire

>>> design/sip_datapath.sv
// Datapath: key registers, SipHash state, length counter and output register.
// Depends on sip_pkg; driven by sip_controller commands.
`default_nettype none

module sip_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [sip_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sip_pkg::WORD_W-1:0]         i_cfg_data,
    input  wire logic [sip_pkg::WORD_W-1:0]         i_message_word,
    input  wire logic [sip_pkg::COUNT_W-1:0]        i_byte_count,
    input  wire logic                               i_last,
    input  wire logic                               i_out_stall,
    input  wire sip_pkg::t_cmd                      i_cmd,
    output sip_pkg::t_status                        o_status,
    output logic                                    o_out_valid,
    output logic [sip_pkg::WORD_W-1:0]              o_hash_value
);

    logic [sip_pkg::WORD_W-1:0] r_key_low, r_key_high;
    sip_pkg::t_sip_state        r_v, n_v;
    logic [sip_pkg::WORD_W-1:0] r_blk, n_blk;
    logic [sip_pkg::LEN_W-1:0]  r_len, n_len;
    logic                       r_in_msg;
    logic                       r_out_valid;
    logic [sip_pkg::WORD_W-1:0] r_hash;

    logic                       full;
    logic [sip_pkg::LEN_W-1:0]  len_base;
    logic [sip_pkg::WORD_W-1:0] masked;
    sip_pkg::t_sip_state        init_v, rnd_in, rnd_out;

    assign full = !i_last || (i_byte_count >= sip_pkg::COUNT_W'(8));
    assign o_status.full     = full;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        init_v.v0 = r_key_low  ^ sip_pkg::SIP_C0;
        init_v.v1 = r_key_high ^ sip_pkg::SIP_C1;
        init_v.v2 = r_key_low  ^ sip_pkg::SIP_C2;
        init_v.v3 = r_key_high ^ sip_pkg::SIP_C3;
    end

    // Keep only the bytes below byte_count of a partial last word
    always_comb begin
        masked = '0;
        for (int i = 0; i < 8; i++) begin
            if (sip_pkg::COUNT_W'(i) < i_byte_count) begin
                masked[i*8 +: 8] = i_message_word[i*8 +: 8];
            end
        end
    end

    assign len_base = r_in_msg ? r_len : '0;

    always_comb begin
        n_len = r_len;
        n_blk = r_blk;
        rnd_in = r_v;
        if (i_cmd.load) begin
            if (full) begin
                n_len = len_base + sip_pkg::LEN_W'(8);
                n_blk = i_message_word;
            end else begin
                n_len = len_base + sip_pkg::LEN_W'(i_byte_count);
                n_blk = masked | (sip_pkg::WORD_W'(n_len) << sip_pkg::LEN_SHIFT);
            end
            rnd_in = r_in_msg ? r_v : init_v;
            rnd_in.v3 = rnd_in.v3 ^ n_blk;
        end else if (i_cmd.inject) begin
            n_blk = sip_pkg::WORD_W'(r_len) << sip_pkg::LEN_SHIFT;
            rnd_in.v3 = rnd_in.v3 ^ n_blk;
        end else if (i_cmd.fin) begin
            rnd_in.v2 = rnd_in.v2 ^ sip_pkg::SIP_FINAL_XOR;
        end
        rnd_out = sip_pkg::sip_permute(rnd_in);
        n_v = r_v;
        if (i_cmd.load || i_cmd.inject || i_cmd.fin || i_cmd.step) begin
            n_v = rnd_out;
            if (i_cmd.mix) begin
                n_v.v0 = rnd_out.v0 ^ r_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_v         <= '0;
            r_len       <= '0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    sip_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    sip_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                    default: ;
                endcase
            end
            r_v   <= n_v;
            r_len <= n_len;
            if (i_cmd.load) begin
                r_in_msg <= 1'b1;
            end else if (i_cmd.done) begin
                r_in_msg <= 1'b0;
            end
            if (i_cmd.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        if (i_cmd.done) begin
            r_hash <= r_v.v0 ^ r_v.v1 ^ r_v.v2 ^ r_v.v3;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

endmodule

`default_nettype wire

>>> design/sip_controller.sv
// Controller state machine: sequences rounds for words, length block and finalization.
// Depends on sip_pkg; commands sip_datapath.
`default_nettype none

module sip_controller (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_last,
    input  wire sip_pkg::t_status   i_status,
    output logic                    o_in_stall,
    output sip_pkg::t_cmd           o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RND2 = 3'd1;
    localparam logic [2:0] ST_INJ  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_FRND = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_last, n_last;
    logic       r_pend, n_pend;
    logic [1:0] r_cnt, n_cnt;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_last  = i_last;
                    n_pend  = i_last && i_status.full;
                    n_state = ST_RND2;
                end
            end
            ST_RND2: begin
                o_cmd.step = 1'b1;
                o_cmd.mix  = 1'b1;
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_pend) begin
                    n_state = ST_INJ;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_INJ: begin
                o_cmd.inject = 1'b1;
                n_pend  = 1'b0;
                n_state = ST_RND2;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_cnt   = '0;
                n_state = ST_FRND;
            end
            ST_FRND: begin
                o_cmd.step = 1'b1;
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
        end
    end

    a_accept_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RND2))
        else $error("accepted transaction did not start its second round");

    a_final_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRND && r_cnt == 2'd2) |=> (r_state == ST_DONE))
        else $error("finalization did not end after four rounds");

    a_inject_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INJ) |=> (r_state == ST_RND2 && !r_pend))
        else $error("length block not absorbed exactly once");

endmodule

`default_nettype wire

>>> design/siphash_2_4_keyed_hash_unit.sv
// Top level of the SipHash-2-4 keyed hash unit.
// Depends on sip_pkg, sip_controller and sip_datapath.
`default_nettype none

// SipHash-2-4 over a byte message under a 128-bit key (key_low at index 0,
// key_high at index 1). Keys are sampled when the first word of a message is
// taken, so a write during a message applies to the next one. Words arrive
// little-endian, first byte in bits 7:0; byte_count matters only on the last
// transaction, where 0..7 bytes form the final block directly and 8 or more
// absorb the word and then a length-only block. While rounds remain, one
// SipRound runs per cycle on a single shared round unit. One transaction is
// handled at a time: a non-last word runs its compression rounds, and a last
// one also the length block if any, finalization, and a wait for the output
// register to free. The hash sits in an output register, so the next message
// may start while the previous hash still waits to be taken.
module siphash_2_4_keyed_hash_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write port
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [sip_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sip_pkg::WORD_W-1:0]         i_cfg_data,
    // input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [sip_pkg::WORD_W-1:0]         i_message_word,
    input  wire logic [sip_pkg::COUNT_W-1:0]        i_byte_count,
    input  wire logic                               i_last,
    // output channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [sip_pkg::WORD_W-1:0]              o_hash_value
);

    sip_pkg::t_cmd    cmd;
    sip_pkg::t_status status;

    // Sequence rounds; accept a transaction only when idle
    sip_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_last),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold keys, hash state, length and the output register
    sip_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_last         (i_last),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_hash_value   (o_hash_value)
    );

endmodule

`default_nettype wire

>>> verif/siphash_2_4_keyed_hash_unit_checker.sv
// Checker for the SipHash-2-4 keyed hash unit: tracks key writes and input
// transactions, predicts every hash and compares it with the output channel.
// Depends on sip_pkg for widths and register indexes.
module siphash_2_4_keyed_hash_unit_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sip_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sip_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [sip_pkg::WORD_W-1:0]         i_message_word,
    input  logic [sip_pkg::COUNT_W-1:0]        i_byte_count,
    input  logic                               i_last,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [sip_pkg::WORD_W-1:0]         i_hash_value,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] IV0 = 64'h736f6d6570736575;
    localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [63:0] IV2 = 64'h6c7967656e657261;
    localparam logic [63:0] IV3 = 64'h7465646279746573;

    logic [63:0] key_lo, key_hi;
    logic [63:0] lane0, lane1, lane2, lane3;
    logic [7:0]  byte_total;
    logic        mid_message;
    logic [63:0] hash_due[$];
    int          mismatches;

    function automatic void mix_round();
        lane0 = lane0 + lane1;
        lane2 = lane2 + lane3;
        lane1 = {lane1[50:0], lane1[63:51]};
        lane3 = {lane3[47:0], lane3[63:48]};
        lane1 = lane1 ^ lane0;
        lane3 = lane3 ^ lane2;
        lane0 = {lane0[31:0], lane0[63:32]};
        lane2 = lane2 + lane1;
        lane0 = lane0 + lane3;
        lane1 = {lane1[46:0], lane1[63:47]};
        lane3 = {lane3[42:0], lane3[63:43]};
        lane1 = lane1 ^ lane2;
        lane3 = lane3 ^ lane0;
        lane2 = {lane2[31:0], lane2[63:32]};
    endfunction

    function automatic void absorb_block(input logic [63:0] m);
        lane3 = lane3 ^ m;
        mix_round();
        mix_round();
        lane0 = lane0 ^ m;
    endfunction

    // Advance the hash state by one transaction; queue the hash on the last one.
    function automatic void fold_item(input logic [63:0] word, input logic [3:0] count,
                                      input logic is_last);
        logic [63:0] tail;
        tail = '0;
        if (!mid_message) begin
            lane0 = key_lo ^ IV0;
            lane1 = key_hi ^ IV1;
            lane2 = key_lo ^ IV2;
            lane3 = key_hi ^ IV3;
            byte_total = '0;
            mid_message = 1'b1;
        end
        if (!is_last || count >= 4'd8) begin
            absorb_block(word);
            byte_total = byte_total + 8'd8;
            if (!is_last)
                return;
        end else begin
            for (int b = 0; b < count; b++)
                tail[8*b +: 8] = word[8*b +: 8];
            byte_total = byte_total + 8'(count);
        end
        tail[63:56] = byte_total;
        absorb_block(tail);
        lane2 = lane2 ^ 64'hff;
        repeat (4) mix_round();
        hash_due.push_back(lane0 ^ lane1 ^ lane2 ^ lane3);
        mid_message = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_lo = '0;
            key_hi = '0;
            lane0 = '0;
            lane1 = '0;
            lane2 = '0;
            lane3 = '0;
            byte_total = '0;
            mid_message = 1'b0;
            hash_due.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == sip_pkg::REG_KEY_LOW)
                    key_lo = i_cfg_data;
                else if (i_cfg_index == sip_pkg::REG_KEY_HIGH)
                    key_hi = i_cfg_data;
            end
            // Push before pop: a hash leaving now always belongs to an older message.
            if (i_in_valid && !i_in_stall)
                fold_item(i_message_word, i_byte_count, i_last);
            if (i_out_valid && !i_out_stall) begin
                if (hash_due.size() == 0) begin
                    $error("hash_value %h arrived with no hash due", i_hash_value);
                    mismatches++;
                end else if (i_hash_value !== hash_due[0]) begin
                    $error("hash_value mismatch: expected %h, actual %h",
                           hash_due[0], i_hash_value);
                    mismatches++;
                    void'(hash_due.pop_front());
                end else begin
                    void'(hash_due.pop_front());
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= hash_due.size();
    end

endmodule

>>> verif/siphash_2_4_keyed_hash_unit_tb.sv
// Testbench top for the SipHash-2-4 keyed hash unit: drives keys, messages
// and output stalls; the checker beside the block predicts and compares.
// Depends on sip_pkg, the RTL and siphash_2_4_keyed_hash_unit_checker.
module siphash_2_4_keyed_hash_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 1000;  // cycles with no transaction before giving up
    localparam int SETTLE      = 12;    // covers the longest per-transaction latency
    localparam int RANDOM_ITEMS = 370;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [sip_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sip_pkg::WORD_W-1:0]    i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [sip_pkg::WORD_W-1:0]    i_message_word;
    logic [sip_pkg::COUNT_W-1:0]   i_byte_count;
    logic                          i_last;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [sip_pkg::WORD_W-1:0]    o_hash_value;

    int fail_count;
    int hashes_pending;
    int words_sent;
    int quiet_cycles;
    bit send_calm;   // when set the sender never idles
    bit take_calm;   // when set the receiver never stalls

    siphash_2_4_keyed_hash_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_message_word(i_message_word),
        .i_byte_count  (i_byte_count),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hash_value  (o_hash_value)
    );

    siphash_2_4_keyed_hash_unit_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_message_word(i_message_word),
        .i_byte_count  (i_byte_count),
        .i_last        (i_last),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_hash_value  (o_hash_value),
        .o_fail_count  (fail_count),
        .o_pending     (hashes_pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a run that stops moving transactions is a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("siphash_2_4_keyed_hash_unit_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: draw a stall length per hash, then take the next one.
    initial begin : result_taker
        int hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = take_calm ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Present one transaction after an optional gap; return at the edge that takes it.
    task automatic send_word(input logic [63:0] word, input logic [3:0] count,
                             input logic is_last);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_message_word <= word;
        i_byte_count   <= count;
        i_last         <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // Drop valid, wait for every hash due, then let the block finish any open word.
    // The first edge lets the pending count take in the transaction just sent.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (hashes_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_keys(input logic [63:0] lo, input logic [63:0] hi);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sip_pkg::REG_KEY_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= sip_pkg::REG_KEY_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return rand_word();
        endcase
    endfunction

    // Full non-last words carry junk byte counts, which the block must ignore.
    task automatic send_message(input int body_words);
        int tail_count;
        repeat (body_words) send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
        tail_count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                 : $urandom_range(0, 8);
        send_word(rand_word(), 4'(tail_count), 1'b1);
    endtask

    initial begin : stimulus
        int phase;
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_index    <= sip_pkg::REG_KEY_LOW;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_message_word <= '0;
        i_byte_count   <= '0;
        i_last         <= 1'b0;
        send_calm = 1'b0;
        take_calm = 1'b0;
        words_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty message under the reset key.
        send_word(rand_word(), 4'd0, 1'b1);
        settle();
        write_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);

        // Tail sizes: empty, one byte with junk above it, seven bytes, full word,
        // and counts above eight which act as a full word.
        send_word(rand_word(), 4'd0, 1'b1);
        send_word(64'hdeadbeefcafef00d, 4'd1, 1'b1);
        send_word(64'hffffffffffffffff, 4'd7, 1'b1);
        send_word(64'h0706050403020100, 4'd8, 1'b1);
        send_word(rand_word(), 4'd15, 1'b1);
        send_word(rand_word(), 4'd9, 1'b1);
        send_word(64'hffffffffffffffff, 4'd8, 1'b1);
        send_word(64'h0, 4'd8, 1'b1);
        // Short non-last word counts as eight bytes.
        send_word(64'h0706050403020100, 4'd3, 1'b0);
        send_word(64'h000e0d0c0b0a0908, 4'd7, 1'b1);
        send_word(rand_word(), 4'd0, 1'b0);
        send_word(rand_word(), 4'd8, 1'b1);

        // Key write in the middle of a message applies only to the next one.
        send_word(rand_word(), 4'd8, 1'b0);
        settle();
        write_keys('1, '1);
        send_word(rand_word(), 4'd4, 1'b1);
        send_word(rand_word(), 4'd6, 1'b1);
        settle();
        write_keys('0, '1);
        send_word(rand_word(), 4'd2, 1'b1);
        settle();
        write_keys('1, '0);

        // Random phases: well-formed messages with random content, idling
        // modes and keys changing between phases.
        words_sent = 0;
        phase = 0;
        while (words_sent < RANDOM_ITEMS) begin
            send_calm = ($urandom_range(0, 3) == 0);
            take_calm = ($urandom_range(0, 3) == 0);
            if (phase == 2)
                send_message(33);  // wraps the byte length past 255
            repeat ($urandom_range(4, 10))
                send_message(($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                         : $urandom_range(0, 3));
            // Sometimes leave a message open across the key write.
            if ($urandom_range(0, 2) == 0)
                send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
            settle();
            write_keys(pick_key(), pick_key());
            phase++;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("siphash_2_4_keyed_hash_unit_tb passed");
        else
            $display("siphash_2_4_keyed_hash_unit_tb failed");
        $finish;
    end

endmodule
